>>> hdl/cpuwd_pkg.sv
// ----------------------------------------------------------------------------
// cpuwd_pkg
// Shared widths, result codes and controller/datapath interface structs for
// the CPU share runaway watchdog.
// ----------------------------------------------------------------------------
package cpuwd_pkg;

    localparam int TIME_W  = 32;
    localparam int ID_W    = 32;
    localparam int SHARE_W = 14;
    localparam int THR_W   = 14;
    localparam int LIMIT_W = 8;
    localparam int STAT_W  = 3;
    localparam int PROD_W  = TIME_W + SHARE_W;
    localparam int DCNT_W  = $clog2(SHARE_W);

    // full share, 100.00 percent in hundredths
    localparam logic [SHARE_W-1:0] SHARE_FULL      = 14'd10000;
    localparam logic [THR_W-1:0]   RESET_THRESHOLD = 14'd8000;
    localparam logic [LIMIT_W-1:0] RESET_LIMIT     = 8'd5;

    // result status codes
    localparam logic [STAT_W-1:0] ST_PRIMED   = 3'd0;
    localparam logic [STAT_W-1:0] ST_INTERVAL = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOT_ELIG = 3'd2;
    localparam logic [STAT_W-1:0] ST_BELOW    = 3'd3;
    localparam logic [STAT_W-1:0] ST_BREACH   = 3'd4;
    localparam logic [STAT_W-1:0] ST_TERM     = 3'd5;

    // configuration register indexes
    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_LIMIT     = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic load_sample;
        logic latch_delta;
        logic load_prod;
        logic div_init;
        logic div_step;
        logic commit;
    } cpuwd_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic early;
        logic div_last;
        logic out_free;
    } cpuwd_sts_t;

endpackage

>>> hdl/cpuwd_ctrl.sv
// ----------------------------------------------------------------------------
// cpuwd_ctrl
// Sequencer for one sample: capture, delta, multiply, serial divide, commit.
// ----------------------------------------------------------------------------
module cpuwd_ctrl
    import cpuwd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  cpuwd_sts_t sts,
    output cpuwd_cmd_t cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DELTA  = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_DINIT  = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_sample = 1'b1;
                    state_next      = S_DELTA;
                end
            end
            S_DELTA:
            begin
                cmd.latch_delta = 1'b1;
                state_next      = S_MUL;
            end
            S_MUL:
            begin
                if (sts.early)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.load_prod = 1'b1;
                    state_next    = S_DINIT;
                end
            end
            S_DINIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // the divider only steps inside its own state
    a_step_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> state_reg == S_DIV)
        else $error("divider step outside divide state");

    a_commit_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> state_reg == S_IDLE)
        else $error("commit did not return to idle");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_sample |=> state_reg == S_DELTA)
        else $error("accepted sample not processed");

endmodule

>>> hdl/cpuwd_dpath.sv
// ----------------------------------------------------------------------------
// cpuwd_dpath
// Sample registers, deltas, share multiply, 14-step restoring divider,
// breach tracking, configuration registers and the output register.
// ----------------------------------------------------------------------------
module cpuwd_dpath
    import cpuwd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cpuwd_cmd_t                cmd,
    output cpuwd_sts_t                sts,
    // sample
    input  logic [TIME_W-1:0]         total_time,
    input  logic [TIME_W-1:0]         app_time,
    input  logic signed [ID_W-1:0]    app_id,
    input  logic                      is_eligible,
    // configuration
    input  logic                      cfg_valid,
    input  logic                      cfg_index,
    input  logic [THR_W-1:0]          cfg_data,
    // result
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [STAT_W-1:0]         status,
    output logic [SHARE_W-1:0]        load_share,
    output logic                      terminate
);

    // configuration
    logic [THR_W-1:0]   threshold_reg;
    logic [LIMIT_W-1:0] limit_reg;

    // captured sample
    logic [TIME_W-1:0] s_total_reg;
    logic [TIME_W-1:0] s_app_reg;
    logic [ID_W-1:0]   s_id_reg;
    logic              s_elig_reg;

    // persistent state
    logic              have_prev_reg;
    logic [TIME_W-1:0] prev_total_reg;
    logic [TIME_W-1:0] prev_app_reg;
    logic [ID_W-1:0]   prev_id_reg;
    logic [ID_W-1:0]   tracked_id_reg;
    logic [LIMIT_W-1:0] count_reg;

    // arithmetic
    logic [TIME_W-1:0]  d_total_reg;
    logic [TIME_W-1:0]  d_app_reg;
    logic               intv_reg;
    logic               cap_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [TIME_W-1:0]  rem_reg;
    logic [SHARE_W-1:0] lo_reg;
    logic [SHARE_W-1:0] quot_reg;
    logic [DCNT_W-1:0]  dcnt_reg;

    // output register
    logic               out_valid_reg;
    logic [STAT_W-1:0]  status_reg;
    logic [SHARE_W-1:0] share_reg;
    logic               term_reg;

    logic [TIME_W-1:0]  d_total;
    logic [TIME_W-1:0]  d_app;
    logic [TIME_W:0]    shifted;
    logic [TIME_W:0]    diff;
    logic               fits;

    logic [STAT_W-1:0]  res_status;
    logic [SHARE_W-1:0] res_share;
    logic               res_term;
    logic [SHARE_W-1:0] share_sel;
    logic [LIMIT_W-1:0] cnt_base;
    logic [LIMIT_W-1:0] cnt_inc;
    logic [LIMIT_W-1:0] count_next;
    logic [ID_W-1:0]    tracked_id_next;

    assign d_total = s_total_reg - prev_total_reg;
    assign d_app   = s_app_reg - prev_app_reg;

    // divider step: shift in next dividend bit, subtract when it fits
    assign shifted = {rem_reg, lo_reg[SHARE_W-1]};
    assign diff    = shifted - {1'b0, d_total_reg};
    assign fits    = (shifted >= {1'b0, d_total_reg});

    assign sts.early    = !have_prev_reg || intv_reg;
    assign sts.div_last = (dcnt_reg == DCNT_W'(SHARE_W - 1));
    assign sts.out_free = !out_valid_reg || !out_stall;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= RESET_THRESHOLD;
            limit_reg     <= RESET_LIMIT;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD: threshold_reg <= cfg_data;
                CFG_LIMIT:     limit_reg     <= cfg_data[LIMIT_W-1:0];
                default:       threshold_reg <= threshold_reg;
            endcase
        end
    end

    // sample capture, deltas, multiply and divide
    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
        begin
            s_total_reg <= total_time;
            s_app_reg   <= app_time;
            s_id_reg    <= $unsigned(app_id);
            s_elig_reg  <= is_eligible;
        end
        if (cmd.latch_delta)
        begin
            d_total_reg <= d_total;
            d_app_reg   <= d_app;
            intv_reg    <= (d_total == '0) || (prev_id_reg != s_id_reg);
            cap_reg     <= (d_app >= d_total);
        end
        if (cmd.load_prod)
        begin
            prod_reg <= PROD_W'(d_app_reg) * PROD_W'(SHARE_FULL);
        end
        if (cmd.div_init)
        begin
            rem_reg  <= prod_reg[PROD_W-1:SHARE_W];
            lo_reg   <= prod_reg[SHARE_W-1:0];
            quot_reg <= '0;
            dcnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= fits ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
            lo_reg   <= {lo_reg[SHARE_W-2:0], 1'b0};
            quot_reg <= {quot_reg[SHARE_W-2:0], fits};
            dcnt_reg <= dcnt_reg + DCNT_W'(1);
        end
    end

    // result decision
    always_comb
    begin
        share_sel       = cap_reg ? SHARE_FULL : quot_reg;
        cnt_base        = (tracked_id_reg != s_id_reg) ? '0 : count_reg;
        cnt_inc         = cnt_base + LIMIT_W'(1);
        res_status      = ST_PRIMED;
        res_share       = '0;
        res_term        = 1'b0;
        count_next      = count_reg;
        tracked_id_next = tracked_id_reg;
        priority if (!have_prev_reg)
        begin
            res_status = ST_PRIMED;
        end
        else if (intv_reg)
        begin
            res_status      = ST_INTERVAL;
            count_next      = '0;
            tracked_id_next = '0;
        end
        else if (!s_elig_reg)
        begin
            res_status      = ST_NOT_ELIG;
            res_share       = share_sel;
            count_next      = '0;
            tracked_id_next = '0;
        end
        else if (share_sel < threshold_reg)
        begin
            res_status      = ST_BELOW;
            res_share       = share_sel;
            count_next      = '0;
            tracked_id_next = s_id_reg;
        end
        else if (cnt_inc < limit_reg)
        begin
            res_status      = ST_BREACH;
            res_share       = share_sel;
            count_next      = cnt_inc;
            tracked_id_next = s_id_reg;
        end
        else
        begin
            res_status      = ST_TERM;
            res_share       = share_sel;
            res_term        = 1'b1;
            count_next      = '0;
            tracked_id_next = '0;
        end
    end

    // persistent state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg  <= 1'b0;
            prev_total_reg <= '0;
            prev_app_reg   <= '0;
            prev_id_reg    <= '0;
            tracked_id_reg <= '0;
            count_reg      <= '0;
        end
        else if (cmd.commit)
        begin
            have_prev_reg  <= 1'b1;
            prev_total_reg <= s_total_reg;
            prev_app_reg   <= s_app_reg;
            prev_id_reg    <= s_id_reg;
            tracked_id_reg <= tracked_id_next;
            count_reg      <= count_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg <= res_status;
            share_reg  <= res_share;
            term_reg   <= res_term;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign load_share = share_reg;
    assign terminate  = term_reg;

    a_term_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (term_reg == (status_reg == ST_TERM)))
        else $error("terminate flag disagrees with status");

    a_share_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> share_reg <= SHARE_FULL)
        else $error("share above full scale");

    a_commit_primes: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (have_prev_reg && out_valid_reg))
        else $error("commit did not prime state or load output");

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> sts.out_free)
        else $error("result overwritten before delivery");

endmodule

>>> hdl/cpu_share_runaway_watchdog.sv
// ----------------------------------------------------------------------------
// cpu_share_runaway_watchdog
// Per-sample CPU share watchdog: computes the app share of run time and
// orders termination after a run of consecutive breaching samples.
//
// Channel  Direction  Handshake               Payload
// in       sink       in_valid / in_stall     total_time, app_time, app_id,
//                                             is_eligible
// out      source     out_valid / out_stall   status, load_share, terminate
// cfg      sink       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One sample at a time. A priming or interval-reset sample skips the share
// multiply and the divide; every other sample runs the share multiply and
// then the 14-step restoring divider (one quotient bit per cycle). The
// result sits in an output register; a new sample is accepted while it
// waits, and the next result is held back in the finish state until that
// one is taken.
// Reset (rst_n, asynchronous) restores threshold 8000, limit 5 and unprimed
// state. cfg_ready is always high.
// ----------------------------------------------------------------------------
module cpu_share_runaway_watchdog
    import cpuwd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // sample input
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [TIME_W-1:0]      total_time,
    input  logic [TIME_W-1:0]      app_time,
    input  logic signed [ID_W-1:0] app_id,
    input  logic                   is_eligible,
    // result output
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [STAT_W-1:0]      status,
    output logic [SHARE_W-1:0]     load_share,
    output logic                   terminate,
    // configuration
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_index,
    input  logic [THR_W-1:0]       cfg_data
);

    cpuwd_cmd_t cmd;
    cpuwd_sts_t sts;

    assign cfg_ready = 1'b1;

    cpuwd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    cpuwd_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .total_time  (total_time),
        .app_time    (app_time),
        .app_id      (app_id),
        .is_eligible (is_eligible),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .load_share  (load_share),
        .terminate   (terminate)
    );

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the CPU share runaway watchdog. A queue-fed driver
// sends periodic samples with random gaps, a monitor takes results under
// random stall and checks each one against an in-bench share/breach predictor.
// The run walks through several threshold and limit settings, extremes
// included, each written while the block is idle.
// ----------------------------------------------------------------------------
module tb
    import cpuwd_pkg::*;
();

    typedef struct packed {
        logic [TIME_W-1:0]      total;
        logic [TIME_W-1:0]      app;
        logic signed [ID_W-1:0] id;
        logic                   elig;
    } sample_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [SHARE_W-1:0] share;
        logic               kill;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [TIME_W-1:0]      total_time = '0;
    logic [TIME_W-1:0]      app_time = '0;
    logic signed [ID_W-1:0] app_id = '0;
    logic                   is_eligible = 1'b0;

    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [STAT_W-1:0]      status;
    logic [SHARE_W-1:0]     load_share;
    logic                   terminate;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic                   cfg_index = CFG_THRESHOLD;
    logic [THR_W-1:0]       cfg_data = '0;

    cpu_share_runaway_watchdog dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .total_time  (total_time),
        .app_time    (app_time),
        .app_id      (app_id),
        .is_eligible (is_eligible),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .load_share  (load_share),
        .terminate   (terminate),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // clock, 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // samples waiting to be sent, verdicts waiting for their result
    sample_t  sample_q[$];
    verdict_t verdict_q[$];
    int       err_count = 0;
    bit       calm = 1'b0;

    // predictor copy of registers and watchdog state
    logic [THR_W-1:0]       thr_reg = RESET_THRESHOLD;
    logic [LIMIT_W-1:0]     lim_reg = RESET_LIMIT;
    logic                   primed = 1'b0;
    logic [TIME_W-1:0]      last_total = '0;
    logic [TIME_W-1:0]      last_app = '0;
    logic signed [ID_W-1:0] last_id = '0;
    logic signed [ID_W-1:0] watch_id = '0;
    logic [7:0]             strikes = '0;

    // stimulus generator counters
    logic [TIME_W-1:0]      gen_total = '0;
    logic [TIME_W-1:0]      gen_app = '0;
    logic signed [ID_W-1:0] gen_id = '0;

    task automatic report_mismatch(string what, int got, int exp);
        $display("%0t ns mismatch %s: got %0d expected %0d", $realtime, what, got, exp);
        err_count++;
    endtask

    // mostly short gaps, now and then a long one
    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // share and breach verdict for one accepted sample; updates state
    function automatic verdict_t watchdog_verdict(sample_t s);
        logic [TIME_W-1:0]      d_total;
        logic [TIME_W-1:0]      d_app;
        logic signed [ID_W-1:0] prev_id;
        logic [63:0]            quot;
        logic [SHARE_W-1:0]     share;
        verdict_t               v;
        v = '0;
        if (!primed)
        begin
            last_total = s.total;
            last_app = s.app;
            last_id = s.id;
            primed = 1'b1;
            v.status = ST_PRIMED;
            return v;
        end
        d_total = s.total - last_total;
        d_app = s.app - last_app;
        last_total = s.total;
        last_app = s.app;
        prev_id = last_id;
        last_id = s.id;
        if (d_total == '0 || prev_id != s.id)
        begin
            watch_id = '0;
            strikes = '0;
            v.status = ST_INTERVAL;
            return v;
        end
        quot = ({32'd0, d_app} * 64'd10000) / {32'd0, d_total};
        share = (quot > 64'd10000) ? SHARE_FULL : quot[SHARE_W-1:0];
        v.share = share;
        if (!s.elig)
        begin
            watch_id = '0;
            strikes = '0;
            v.status = ST_NOT_ELIG;
            return v;
        end
        if (watch_id != s.id)
        begin
            watch_id = s.id;
            strikes = '0;
        end
        if (share < thr_reg)
        begin
            strikes = '0;
            v.status = ST_BELOW;
            return v;
        end
        strikes = strikes + 8'd1;
        if (strikes < lim_reg)
        begin
            v.status = ST_BREACH;
            return v;
        end
        watch_id = '0;
        strikes = '0;
        v.status = ST_TERM;
        v.kill = 1'b1;
        return v;
    endfunction

    // sample driver
    int  send_gap = 0;
    bit  send_free;
    sample_t next_s;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            send_free = !in_valid;
            if (in_valid && !in_stall)
            begin
                verdict_q.push_back(watchdog_verdict({total_time, app_time, app_id,
                                                      is_eligible}));
                send_free = 1'b1;
            end
            if (send_free)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (sample_q.size() > 0)
                begin
                    next_s = sample_q.pop_front();
                    total_time <= next_s.total;
                    app_time <= next_s.app;
                    app_id <= next_s.id;
                    is_eligible <= next_s.elig;
                    in_valid <= 1'b1;
                    send_gap = next_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor and stall pattern
    int       stall_left = 0;
    verdict_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (verdict_q.size() == 0)
                    report_mismatch("result with nothing pending, status", int'(status), -1);
                else
                begin
                    want = verdict_q.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", int'(status), int'(want.status));
                    if (load_share !== want.share)
                        report_mismatch("load_share", int'(load_share), int'(want.share));
                    if (terminate !== want.kill)
                        report_mismatch("terminate", int'(terminate), int'(want.kill));
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (!calm && $urandom_range(0, 3) == 0)
                    stall_left = next_gap();
            end
        end
    end

    task automatic put(logic [31:0] tot, logic [31:0] app, logic signed [31:0] id,
                       logic elig);
        gen_total = tot;
        gen_app = app;
        gen_id = id;
        sample_q.push_back({tot, app, id, elig});
    endtask

    task automatic step(logic [31:0] dt, logic [31:0] da, logic signed [31:0] id,
                        logic elig);
        put(gen_total + dt, gen_app + da, id, elig);
    endtask

    function automatic logic signed [31:0] pick_id();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 32'sd0;
            1: return 32'sh8000_0000;
            2: return 32'sh7FFF_FFFF;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // one run of samples; bias 0 random share, 1 around threshold, 2 at or below it
    task automatic app_run(int n, bit fresh, bit clean, int bias);
        logic signed [31:0] id;
        logic [31:0]        dt;
        logic [63:0]        prod;
        int                 r;
        int                 t;
        id = fresh ? pick_id() : gen_id;
        for (int i = 0; i < n; i++)
        begin
            r = clean ? 100 : $urandom_range(0, 99);
            if (r < 2)
                step(32'd0, $urandom_range(0, 50), id, 1'b1);
            else if (r < 5)
            begin
                id = pick_id();
                step($urandom_range(1, 1000), $urandom_range(0, 1000), id, 1'b1);
            end
            else if (r < 9)
                put($urandom, $urandom, ($urandom_range(0, 3) == 0) ? id : $urandom,
                    1'($urandom_range(0, 1)));
            else
            begin
                r = $urandom_range(0, 99);
                if (clean || r < 55)
                    dt = $urandom_range(1, 100000);
                else if (r < 80)
                    dt = $urandom;
                else if (r < 92)
                    dt = $urandom_range(1, 16);
                else
                    dt = 32'hFFFF_FFFF - $urandom_range(0, 3);
                if (bias == 1)
                    t = int'(thr_reg) - (clean ? 0 : 40) + $urandom_range(0, 200);
                else if (bias == 2)
                    t = $urandom_range(0, int'(thr_reg));
                else
                    t = $urandom_range(0, 11000);
                if (t > 12000)
                    t = 12000;
                if (t < 0)
                    t = 0;
                // rounding up keeps the share at or above the target
                prod = ({32'd0, dt} * 64'(t) + 64'd9999) / 64'd10000;
                step(dt, prod[31:0], id, clean ? 1'b1 : ($urandom_range(0, 19) != 0));
            end
        end
    endtask

    task automatic write_reg(logic idx, logic [THR_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_THRESHOLD)
            thr_reg = data;
        else
            lim_reg = data[LIMIT_W-1:0];
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(int thr, int lim);
        logic [5:0] junk;
        junk = 6'($urandom);
        write_reg(CFG_THRESHOLD, THR_W'(thr));
        write_reg(CFG_LIMIT, {junk, LIMIT_W'(lim)});
    endtask

    // wait for every result, then let the block settle; checked between edges
    task automatic drain();
        while (sample_q.size() != 0 || in_valid || verdict_q.size() != 0)
            @(negedge clk);
        repeat (25) @(posedge clk);
    endtask

    // run limit
    initial
    begin
        #4ms;
        $display("*** FAILED ***");
        $finish;
    end

    // main sequence
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: priming, zero delta, wrap, cap, id change, breach run
        put(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'sh8000_0000, 1'b0);
        put(32'hFFFF_FFFF, 32'h0000_0000, 32'sh8000_0000, 1'b1);
        step(32'd100, 32'd100, 32'sh8000_0000, 1'b0);
        step(32'd100, 32'd50, 32'sh7FFF_FFFF, 1'b1);
        repeat (5) step(32'd10000, 32'd9000, 32'sh7FFF_FFFF, 1'b1);
        step(32'd10000, 32'd20000, 32'sh7FFF_FFFF, 1'b1);
        step(32'd10000, 32'd100, 32'sh7FFF_FFFF, 1'b1);
        step(32'd10000, 32'd7999, 32'sh7FFF_FFFF, 1'b1);
        step(32'd10000, 32'd8000, 32'sh7FFF_FFFF, 1'b1);
        step(32'd3, 32'd0, 32'sd0, 1'b1);
        step(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'sd0, 1'b1);
        step(32'd1, 32'd0, 32'sd0, 1'b0);
        step(32'd7, 32'd7, 32'sd0, 1'b1);
        step(32'hFFFF_FFFF, 32'd0, 32'sd0, 1'b1);
        drain();

        // every share breaches, every breach terminates
        set_regs(0, 1);
        app_run(150, 1'b1, 1'b0, 0);
        drain();

        // full share only, long counting run up to the largest limit
        set_regs(10000, 255);
        app_run(270, 1'b1, 1'b1, 1);
        app_run(50, 1'b0, 1'b0, 1);
        drain();

        // threshold out of reach
        set_regs(16383, 3);
        app_run(120, 1'b1, 1'b0, 1);
        drain();

        // limit of zero
        set_regs(5000, 0);
        app_run(150, 1'b1, 1'b0, 1);
        drain();

        set_regs(9999, 2);
        app_run(150, 1'b1, 1'b0, 1);
        drain();

        // defaults again, no idling on either side
        calm = 1'b1;
        set_regs(8000, 5);
        app_run(150, 1'b1, 1'b0, 1);
        drain();
        calm = 1'b0;

        // build a count, then lower the limit under it
        set_regs(3000, 200);
        app_run(40, 1'b1, 1'b1, 1);
        drain();
        set_regs(3000, 10);
        app_run(60, 1'b0, 1'b1, 1);
        drain();

        // random settings
        repeat (3)
        begin
            set_regs(($urandom_range(0, 4) == 0) ? $urandom_range(0, 16383)
                                                 : $urandom_range(0, 10000),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(1, 12));
            app_run(170, 1'b1, 1'b0, $urandom_range(0, 2));
            app_run(20, 1'b1, 1'b0, 1);
            drain();
        end

        repeat (40) @(posedge clk);
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
